[rtl/round_robin_slice_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler assertion macros
// Shared concurrent assertion forms for the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_DEFINES_SVH

// Assertion that is switched off while reset is asserted.
`define RRS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Assertion that is also checked across reset.
`define RRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rrs_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler package
// Sizes, operation codes and shared types of the scheduler.
// ----------------------------------------------------------------------------
package rrs_pkg;

    localparam int MAX_PROCS = 128;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int ID_W      = 8;
    localparam int TIME_W    = 16;
    localparam int ELAPSED_W = 32;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd4;

    typedef struct packed {
        logic [ID_W-1:0]      process_id;
        logic [TIME_W-1:0]    units_run;
        logic [ELAPSED_W-1:0] elapsed_time;
        logic                 job_finished;
        logic                 all_done;
    } res_t;

    typedef struct packed {
        logic [TIME_W-1:0]    units;
        logic [TIME_W-1:0]    new_rem;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 finished;
    } slice_t;

endpackage

[rtl/rrs_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/rrs_slice.sv]
// ----------------------------------------------------------------------------
// Round-robin slice arithmetic
// Grants one slice to a job and advances the saturating elapsed time.
// ----------------------------------------------------------------------------
module rrs_slice (
    input  logic [rrs_pkg::TIME_W-1:0]    rem,
    input  logic [rrs_pkg::TIME_W-1:0]    quantum,
    input  logic [rrs_pkg::ELAPSED_W-1:0] elapsed,
    output rrs_pkg::slice_t               slice
);

    logic [rrs_pkg::TIME_W-1:0]  q_eff;
    logic [rrs_pkg::ELAPSED_W:0] sum;

    always_comb begin
        // A zero quantum behaves as a single unit.
        q_eff          = (quantum == '0) ? rrs_pkg::TIME_W'(1) : quantum;
        slice.units    = (rem > q_eff) ? q_eff : rem;
        slice.new_rem  = rem - slice.units;
        slice.finished = (slice.new_rem == '0);
        sum            = {1'b0, elapsed} + (rrs_pkg::ELAPSED_W + 1)'(slice.units);
        slice.elapsed  = sum[rrs_pkg::ELAPSED_W] ? '1 : sum[rrs_pkg::ELAPSED_W-1:0];
    end

endmodule

[rtl/rrs_ctrl.sv]
// ----------------------------------------------------------------------------
// Round-robin scheduler control
// Sequencer that owns the job table RAM and scans it one entry per cycle.
// ----------------------------------------------------------------------------
module rrs_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rrs_pkg::OP_W-1:0]   in_op,
    input  logic [rrs_pkg::TIME_W-1:0] in_burst,
    input  logic [rrs_pkg::TIME_W-1:0] quantum,
    output logic                       res_valid,
    input  logic                       res_ready,
    output rrs_pkg::res_t              res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [rrs_pkg::CNT_W-1:0]       job_count_reg, job_count_next;
    logic [rrs_pkg::IDX_W-1:0]       scan_pos_reg, scan_pos_next;
    logic [rrs_pkg::ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [rrs_pkg::IDX_W-1:0]       cur_idx_reg, cur_idx_next;
    logic [rrs_pkg::CNT_W-1:0]       scanned_reg, scanned_next;
    rrs_pkg::res_t                   res_reg, res_next;

    logic                            ram_we;
    logic [rrs_pkg::IDX_W-1:0]       ram_waddr;
    logic [rrs_pkg::TIME_W-1:0]      ram_wdata;
    logic [rrs_pkg::IDX_W-1:0]       ram_raddr;
    logic [rrs_pkg::TIME_W-1:0]      ram_rdata;

    logic [rrs_pkg::IDX_W-1:0]       start_idx;
    logic [rrs_pkg::IDX_W-1:0]       wrap_idx;
    logic [rrs_pkg::CNT_W-1:0]       cur_plus1;
    rrs_pkg::slice_t                 slice;

    rrs_ram #(
        .WIDTH (rrs_pkg::TIME_W),
        .DEPTH (rrs_pkg::MAX_PROCS)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rrs_slice u_slice (
        .rem     (ram_rdata),
        .quantum (quantum),
        .elapsed (elapsed_reg),
        .slice   (slice)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = res_reg;

    always_comb begin
        start_idx = (rrs_pkg::CNT_W'(scan_pos_reg) < job_count_reg) ? scan_pos_reg : '0;
        cur_plus1 = rrs_pkg::CNT_W'(cur_idx_reg) + rrs_pkg::CNT_W'(1);
        wrap_idx  = (cur_plus1 == job_count_reg) ? '0 : rrs_pkg::IDX_W'(cur_plus1);
    end

    always_comb begin
        state_next     = state_reg;
        job_count_next = job_count_reg;
        scan_pos_next  = scan_pos_reg;
        elapsed_next   = elapsed_reg;
        cur_idx_next   = cur_idx_reg;
        scanned_next   = scanned_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_idx_reg;
        ram_wdata      = slice.new_rem;
        ram_raddr      = cur_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_op)
                        rrs_pkg::OP_CLEAR: begin
                            job_count_next = '0;
                            scan_pos_next  = '0;
                            elapsed_next   = '0;
                        end
                        rrs_pkg::OP_LOAD: begin
                            if (job_count_reg < rrs_pkg::CNT_W'(rrs_pkg::MAX_PROCS)) begin
                                ram_we         = 1'b1;
                                ram_waddr      = job_count_reg[rrs_pkg::IDX_W-1:0];
                                ram_wdata      = in_burst;
                                job_count_next = job_count_reg + rrs_pkg::CNT_W'(1);
                            end
                        end
                        rrs_pkg::OP_STEP: begin
                            if (job_count_reg == '0) begin
                                res_next.process_id   = '0;
                                res_next.units_run    = '0;
                                res_next.elapsed_time = elapsed_reg;
                                res_next.job_finished = 1'b0;
                                res_next.all_done     = 1'b1;
                                state_next            = ST_EMIT;
                            end else begin
                                cur_idx_next = start_idx;
                                ram_raddr    = start_idx;
                                scanned_next = '0;
                                state_next   = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (ram_rdata != '0) begin
                    ram_we        = 1'b1;
                    elapsed_next  = slice.elapsed;
                    scan_pos_next = (cur_plus1 < job_count_reg) ?
                                    rrs_pkg::IDX_W'(cur_plus1) : '0;
                    res_next.process_id   = rrs_pkg::ID_W'(cur_plus1);
                    res_next.units_run    = slice.units;
                    res_next.elapsed_time = slice.elapsed;
                    res_next.job_finished = slice.finished;
                    res_next.all_done     = 1'b0;
                    state_next            = ST_EMIT;
                end else if (scanned_reg + rrs_pkg::CNT_W'(1) == job_count_reg) begin
                    res_next.process_id   = '0;
                    res_next.units_run    = '0;
                    res_next.elapsed_time = elapsed_reg;
                    res_next.job_finished = 1'b0;
                    res_next.all_done     = 1'b1;
                    state_next            = ST_EMIT;
                end else begin
                    scanned_next = scanned_reg + rrs_pkg::CNT_W'(1);
                    cur_idx_next = wrap_idx;
                    ram_raddr    = wrap_idx;
                end
            end
            ST_EMIT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            job_count_reg <= '0;
            scan_pos_reg  <= '0;
            elapsed_reg   <= '0;
            cur_idx_reg   <= '0;
            scanned_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            job_count_reg <= job_count_next;
            scan_pos_reg  <= scan_pos_next;
            elapsed_reg   <= elapsed_next;
            cur_idx_reg   <= cur_idx_next;
            scanned_reg   <= scanned_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

[rtl/round_robin_slice_scheduler.sv]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler
// Time-quantum scheduler over a RAM table of remaining job burst times.
//
// Each input transfer carries an operation: clear empties the table and zeroes
// the scan position and elapsed time, load appends a burst time (dropped when
// the table is full), and step grants the next job with time left one quantum
// or its remainder, returning one result transfer. Clear and load return
// nothing. A step reads the table entries in turn until it finds a job with
// time left, at most as many as there are loaded jobs: the single read port
// of the job table RAM reads one entry per cycle. The result sits in an
// output register, so the next transfer is taken while a result waits there.
// The last cycle of a step stretches for as long as the output register
// still holds a result that the receiver has not taken. The quantum register
// is written through cfg_we and cfg_wdata and resets to 4.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [rrs_pkg::TIME_W-1:0]    cfg_wdata,
    // Input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rrs_pkg::OP_W-1:0]      s_operation,
    input  logic [rrs_pkg::TIME_W-1:0]    s_burst_time,
    // Result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rrs_pkg::ID_W-1:0]      m_process_id,
    output logic [rrs_pkg::TIME_W-1:0]    m_units_run,
    output logic [rrs_pkg::ELAPSED_W-1:0] m_elapsed_time,
    output logic                          m_job_finished,
    output logic                          m_all_done
);

    logic [rrs_pkg::TIME_W-1:0] quantum_reg;
    logic                       m_valid_reg;
    rrs_pkg::res_t              out_reg;

    logic                       res_valid;
    logic                       res_ready;
    rrs_pkg::res_t              res;

    // The control block owns the table, the job count, the scan position
    // and the elapsed time; the top level only holds the quantum and the
    // output stage.
    rrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_op     (s_operation),
        .in_burst  (s_burst_time),
        .quantum   (quantum_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // A new result may enter the output register when it is empty or is
    // being drained in the same cycle.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= rrs_pkg::QUANTUM_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                quantum_reg <= cfg_wdata;
            end
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the output stage; it changes only when a new result is
    // loaded, so it holds steady while a transfer is stalled.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_process_id   = out_reg.process_id;
    assign m_units_run    = out_reg.units_run;
    assign m_elapsed_time = out_reg.elapsed_time;
    assign m_job_finished = out_reg.job_finished;
    assign m_all_done     = out_reg.all_done;

endmodule

[rtl/rrs_checker.sv]
// ----------------------------------------------------------------------------
// Round-robin slice scheduler checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "round_robin_slice_scheduler_defines.svh"

module rrs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rrs_pkg::ID_W-1:0]      m_process_id,
    input logic [rrs_pkg::TIME_W-1:0]    m_units_run,
    input logic [rrs_pkg::ELAPSED_W-1:0] m_elapsed_time,
    input logic                          m_job_finished,
    input logic                          m_all_done
);

    // No result is pending right after reset.
    `RRS_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid, "result valid after reset")

    // A stalled result holds its contents.
    `RRS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_process_id) && $stable(m_units_run) && $stable(m_elapsed_time) && $stable(m_job_finished) && $stable(m_all_done), "stalled result changed")

    // An idle report carries no job and no units.
    `RRS_ASSERT(a_done_empty, aclk, aresetn, m_valid && m_all_done |-> m_process_id == '0 && m_units_run == '0 && !m_job_finished, "all-done result carries a slice")

    // A granted slice always runs at least one unit.
    `RRS_ASSERT(a_slice_nonzero, aclk, aresetn, m_valid && !m_all_done |-> m_units_run != '0, "slice of zero units")

endmodule

bind round_robin_slice_scheduler rrs_checker u_rrs_checker (.*);
